FILE: design/dtcc_pkg.sv
// shared constants, codes and types for the distance to control change block
`timescale 1ns / 1ps
`default_nettype none

package dtcc_pkg;

  localparam int FRACTION_BITS_DEF = 8;
  localparam int FIELD_W = 16;
  localparam int ALPHA_W = 9;
  localparam int ALPHA_FRAC = 8;
  localparam int CC_W = 7;
  localparam int QUOT_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 9'd64;
  localparam logic [FIELD_W-1:0] ZONE_RST = 16'd400;
  localparam logic [FIELD_W-1:0] HYST_RST = 16'd50;
  localparam logic [CC_W-1:0] GROUP_RST = 7'd0;

  localparam logic [CC_W-1:0] CC_MAX = 7'd127;
  localparam logic [CC_W-1:0] CC_DIST_SEL = 7'd1;
  localparam logic [CC_W-1:0] CC_PAD_SEL = 7'd2;

  localparam logic [1:0] FUNC_DIST = 2'd0;
  localparam logic [1:0] FUNC_PRIMARY = 2'd1;
  localparam logic [1:0] FUNC_SECONDARY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMP,
    ST_DIV,
    ST_CHK,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

FILE: design/dtcc_mul.sv
// shift-add multiplier, one weight bit per cycle, for the smoothing step
`timescale 1ns / 1ps
`default_nettype none

module dtcc_mul #(
  parameter int DW = dtcc_pkg::FIELD_W + dtcc_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    start,
  input  wire logic [dtcc_pkg::ALPHA_W-1:0]            alpha,
  input  wire logic signed [DW:0]                      diff,
  output logic                                         done,
  output logic signed [DW+dtcc_pkg::ALPHA_W:0]         prod
);
  import dtcc_pkg::*;

  localparam int PW = DW + 1 + ALPHA_W;
  localparam int CNT_W = $clog2(ALPHA_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ALPHA_W - 1);

  logic signed [PW-1:0] acc_r, acc_nxt;
  logic signed [PW-1:0] mcand_r, mcand_nxt;
  logic [ALPHA_W-1:0] mplier_r, mplier_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;

  always_comb begin
    acc_nxt = acc_r;
    mcand_nxt = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0;
      mcand_nxt = $signed({{(PW-DW-1){diff[DW]}}, diff});
      mplier_nxt = alpha;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt = mcand_r <<< 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mcand_r <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

FILE: design/dtcc_div.sv
// restoring divider, one quotient bit per cycle, for the distance to value map
`timescale 1ns / 1ps
`default_nettype none

module dtcc_div #(
  parameter int DW = dtcc_pkg::FIELD_W + dtcc_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [DW+dtcc_pkg::QUOT_W-1:0]  numer,
  input  wire logic [DW-1:0]                   denom,
  output logic                                 done,
  output logic [dtcc_pkg::QUOT_W-1:0]          quot
);
  import dtcc_pkg::*;

  localparam int NW = DW + QUOT_W;
  localparam int CNT_W = $clog2(QUOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);

  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] dv_r, dv_nxt;
  logic [QUOT_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic fits;

  assign fits = rem_r >= dv_r;

  always_comb begin
    rem_nxt = rem_r;
    dv_nxt = dv_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = numer;
      dv_nxt = NW'(denom) << (QUOT_W - 1);
      q_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - dv_r;
      end
      q_nxt = {q_r[QUOT_W-2:0], fits};
      dv_nxt = dv_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dv_r <= dv_nxt;
    q_r <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

FILE: design/distance_to_control_change.sv
// distance to control change: smoothing filter, zone tracking and pad handling
//
// Input channel (in_valid/in_ready) takes one item per transfer: func 0 is a
// distance sample, func 1 the primary pad level, func 2 the secondary pad
// level. Result channel (out_valid/out_ready) carries at most one control
// change per item. Config writes go over cfg_valid/cfg_ready with a register
// index and data; cfg_ready is always high.
// A distance sample inside the zone runs a serial multiply (one weight bit
// per cycle); outside the zone the multiply is skipped. If the smoothed
// distance is then below the zone, a serial divide (one quotient bit per
// cycle) gives the mapped value.
// One item is worked on at a time; in_ready is high only between items.
// A finished result sits in the output register while the next item is
// taken; if it is still unclaimed when another result is ready, the block
// holds that result and stalls its input until out_ready frees the register.
// Reset loads the register defaults and clears all tracking state.
`timescale 1ns / 1ps
`default_nettype none

module distance_to_control_change #(
  parameter int FRACTION_BITS = dtcc_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_func,
  input  wire logic [dtcc_pkg::FIELD_W-1:0]      in_distance_mm,
  input  wire logic                              in_touched,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [dtcc_pkg::CC_W-1:0]              out_cc_number,
  output logic [dtcc_pkg::CC_W-1:0]              out_cc_value,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dtcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dtcc_pkg::FIELD_W-1:0]      cfg_data
);
  import dtcc_pkg::*;

  localparam int DW = FIELD_W + FRACTION_BITS;
  localparam int PW = DW + 1 + ALPHA_W;
  localparam int NW = DW + QUOT_W;
  localparam logic signed [PW-1:0] ROUND = PW'(1) <<< (ALPHA_FRAC - 1);

  state_t state_r, state_nxt;

  logic [ALPHA_W-1:0] alpha_r;
  logic [FIELD_W-1:0] zone_r;
  logic [FIELD_W-1:0] hyst_r;
  logic [CC_W-1:0] group_r;

  logic [DW-1:0] sd_r, sd_nxt;
  logic in_zone_r, in_zone_nxt;
  logic [CC_W-1:0] last_r, last_nxt;
  logic frozen_r, frozen_nxt;
  logic prim_r, prim_nxt;
  logic sec_r, sec_nxt;
  logic [QUOT_W-1:0] qv_r, qv_nxt;
  logic [CC_W-1:0] pend_num_r, pend_num_nxt;
  logic [CC_W-1:0] pend_val_r, pend_val_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [CC_W-1:0] out_num_r, out_val_r;

  logic accept;
  logic emit_load;
  logic mul_start, mul_done;
  logic div_start, div_done;
  logic [ALPHA_W-1:0] alpha_eff;
  logic [DW-1:0] samp;
  logic signed [DW:0] diff;
  logic signed [PW-1:0] mul_prod;
  logic signed [PW-1:0] prod_rnd;
  logic signed [PW-1:0] step;
  logic signed [PW-1:0] sd_sum;
  logic [DW-1:0] zone_fx;
  logic [FIELD_W-1:0] thr;
  logic [DW-1:0] thr_fx;
  logic [DW-1:0] dist_off;
  logic [NW-1:0] numer;
  logic [QUOT_W-1:0] div_quot;
  logic below_zone;
  logic dist_change;

  // datapath terms
  assign accept = in_valid && in_ready;
  assign alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign samp = DW'(in_distance_mm) << FRACTION_BITS;
  assign diff = $signed({1'b0, samp}) - $signed({1'b0, sd_r});
  assign prod_rnd = mul_prod + ROUND;
  assign step = prod_rnd >>> ALPHA_FRAC;
  assign sd_sum = $signed({{(PW-DW){1'b0}}, sd_r}) + step;
  assign zone_fx = DW'(zone_r) << FRACTION_BITS;
  assign thr = in_zone_r ? zone_r : ((hyst_r >= zone_r) ? '0 : zone_r - hyst_r);
  assign thr_fx = DW'(thr) << FRACTION_BITS;
  assign below_zone = sd_r < zone_fx;
  assign dist_off = zone_fx - sd_r;
  assign numer = (NW'(dist_off) << CC_W) - NW'(dist_off);
  assign dist_change = (qv_r != last_r) && !frozen_r;
  assign emit_load = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  dtcc_mul #(
    .DW(DW)
  ) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .alpha(alpha_eff),
    .diff (diff),
    .done (mul_done),
    .prod (mul_prod)
  );

  dtcc_div #(
    .DW(DW)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .numer(numer),
    .denom(zone_fx),
    .done (div_done),
    .quot (div_quot)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_DIST: state_nxt = in_zone_r ? ST_MUL : ST_CMP;
            FUNC_SECONDARY: state_nxt = (in_touched != sec_r) ? ST_EMIT : ST_IDLE;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MUL: if (mul_done) state_nxt = ST_CMP;
      ST_CMP: state_nxt = below_zone ? ST_DIV : ST_CHK;
      ST_DIV: if (div_done) state_nxt = ST_CHK;
      ST_CHK: state_nxt = dist_change ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (emit_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        mul_start = in_valid && (in_func == FUNC_DIST) && in_zone_r;
      end
      ST_CMP: div_start = below_zone;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // tracking state
  always_comb begin
    sd_nxt = sd_r;
    in_zone_nxt = in_zone_r;
    last_nxt = last_r;
    frozen_nxt = frozen_r;
    prim_nxt = prim_r;
    sec_nxt = sec_r;
    qv_nxt = qv_r;
    pend_num_nxt = pend_num_r;
    pend_val_nxt = pend_val_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_DIST: begin
              if (!in_zone_r) sd_nxt = samp;
            end
            FUNC_PRIMARY: begin
              if (in_touched && !prim_r) frozen_nxt = !frozen_r;
              prim_nxt = in_touched;
            end
            FUNC_SECONDARY: begin
              sec_nxt = in_touched;
              pend_num_nxt = group_r | CC_PAD_SEL;
              pend_val_nxt = in_touched ? CC_MAX : '0;
            end
            default: begin
              sd_nxt = sd_r;
            end
          endcase
        end
      end
      ST_MUL: if (mul_done) sd_nxt = sd_sum[DW-1:0];
      ST_CMP: begin
        in_zone_nxt = sd_r < thr_fx;
        qv_nxt = '0;
      end
      ST_DIV: if (div_done) qv_nxt = div_quot;
      ST_CHK: begin
        if (dist_change) begin
          last_nxt = qv_r;
          pend_num_nxt = group_r | CC_DIST_SEL;
          pend_val_nxt = qv_r;
        end
      end
      default: begin
        sd_nxt = sd_r;
      end
    endcase
  end

  always_comb begin
    if (emit_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      alpha_r <= ALPHA_RST;
      zone_r <= ZONE_RST;
      hyst_r <= HYST_RST;
      group_r <= GROUP_RST;
      sd_r <= '0;
      in_zone_r <= 1'b0;
      last_r <= '0;
      frozen_r <= 1'b0;
      prim_r <= 1'b0;
      sec_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sd_r <= sd_nxt;
      in_zone_r <= in_zone_nxt;
      last_r <= last_nxt;
      frozen_r <= frozen_nxt;
      prim_r <= prim_nxt;
      sec_r <= sec_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_ALPHA: alpha_r <= cfg_data[ALPHA_W-1:0];
          CFG_ZONE: zone_r <= cfg_data;
          CFG_HYST: hyst_r <= cfg_data;
          CFG_GROUP: group_r <= cfg_data[CC_W-1:0];
          default: group_r <= group_r;
        endcase
      end
    end
    qv_r <= qv_nxt;
    pend_num_r <= pend_num_nxt;
    pend_val_r <= pend_val_nxt;
    if (emit_load) begin
      out_num_r <= pend_num_r;
      out_val_r <= pend_val_r;
    end
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_cc_number = out_num_r;
  assign out_cc_value = out_val_r;

`ifndef SYNTHESIS
  a_primary_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_func == FUNC_PRIMARY)) |=> (state_r == ST_IDLE))
    else $error("primary pad item did not return to idle");

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MUL))
    else $error("multiplier finished outside its state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside its state");

  a_frozen_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_CHK) && frozen_r) |=> (state_r == ST_IDLE))
    else $error("distance transfer queued while frozen");

  a_cc_number_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_num_r[1:0] != 2'b00))
    else $error("controller number lacks selector bits");
`endif

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// testbench for distance_to_control_change: queued stimulus, running prediction, transfer checks
`timescale 1ns / 1ps

module testbench;
  import dtcc_pkg::*;

  localparam int FRACTION_BITS = FRACTION_BITS_DEF;
  localparam int DIST_W = FIELD_W + FRACTION_BITS;
  localparam int IDLE_PCT = 18;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 68;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [FIELD_W-1:0] distance;
    logic touched;
  } pad_or_distance_t;

  typedef struct packed {
    logic [CC_W-1:0] number;
    logic [CC_W-1:0] value;
  } cc_msg_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [1:0] in_func = FUNC_DIST;
  logic [FIELD_W-1:0] in_distance_mm = '0;
  logic in_touched = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ALPHA;
  logic [FIELD_W-1:0] cfg_data = '0;
  wire in_ready;
  wire out_valid;
  wire [CC_W-1:0] out_cc_number;
  wire [CC_W-1:0] out_cc_value;
  wire cfg_ready;

  pad_or_distance_t pending_items[$];
  pad_or_distance_t next_item;
  cc_msg_t cc_expected[$];
  cc_msg_t oldest_cc;
  int errors = 0;
  bit quiet = 1'b0;
  int drift_mm = 0;

  // predicted register copy and tracking state
  logic [ALPHA_W-1:0] alpha_reg = ALPHA_RST;
  logic [FIELD_W-1:0] zone_reg = ZONE_RST;
  logic [FIELD_W-1:0] hyst_reg = HYST_RST;
  logic [CC_W-1:0] group_reg = GROUP_RST;
  logic [DIST_W-1:0] filt_dist = '0;
  logic tracking = 1'b0;
  logic [CC_W-1:0] last_dist_cc = '0;
  logic freeze = 1'b0;
  logic primary_level = 1'b0;
  logic secondary_level = 1'b0;

  distance_to_control_change uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_distance_mm(in_distance_mm),
    .in_touched(in_touched),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_cc_number(out_cc_number),
    .out_cc_value(out_cc_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic predict_control_change(input logic [1:0] func, input logic [FIELD_W-1:0] mm,
                                        input logic touched);
    logic [63:0] raw_fx;
    logic [63:0] weight;
    logic [63:0] thresh;
    logic [63:0] zone_fx;
    logic [63:0] level;
    cc_msg_t msg;
    case (func)
      FUNC_DIST: begin
        raw_fx = 64'(mm) << FRACTION_BITS;
        weight = (alpha_reg > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha_reg);
        if (tracking) begin
          filt_dist = DIST_W'((weight * raw_fx + (64'(ALPHA_ONE) - weight) * 64'(filt_dist)
                               + (64'd1 << (ALPHA_FRAC - 1))) >> ALPHA_FRAC);
        end else begin
          filt_dist = DIST_W'(raw_fx);
        end
        if (tracking) begin
          thresh = 64'(zone_reg);
        end else begin
          thresh = (hyst_reg >= zone_reg) ? 64'd0 : 64'(zone_reg - hyst_reg);
        end
        tracking = 64'(filt_dist) < (thresh << FRACTION_BITS);
        zone_fx = 64'(zone_reg) << FRACTION_BITS;
        if (64'(filt_dist) >= zone_fx) begin
          level = 64'd0;
        end else begin
          level = (64'(CC_MAX) * (zone_fx - 64'(filt_dist))) / zone_fx;
        end
        if (level[CC_W-1:0] != last_dist_cc && !freeze) begin
          last_dist_cc = level[CC_W-1:0];
          msg.number = group_reg | CC_DIST_SEL;
          msg.value = level[CC_W-1:0];
          cc_expected.push_back(msg);
        end
      end
      FUNC_PRIMARY: begin
        if (touched && !primary_level) begin
          freeze = !freeze;
        end
        primary_level = touched;
      end
      FUNC_SECONDARY: begin
        if (touched != secondary_level) begin
          msg.number = group_reg | CC_PAD_SEL;
          msg.value = touched ? CC_MAX : '0;
          cc_expected.push_back(msg);
        end
        secondary_level = touched;
      end
      default: begin
      end
    endcase
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        next_item = pending_items.pop_front();
        in_valid <= 1'b1;
        in_func <= next_item.func;
        in_distance_mm <= next_item.distance;
        in_touched <= next_item.touched;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // monitor: check result transfers, track config writes, predict on input transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (cc_expected.size() == 0) begin
          $error("unexpected control change number %0d value %0d", out_cc_number, out_cc_value);
          errors++;
        end else begin
          oldest_cc = cc_expected.pop_front();
          if (out_cc_number !== oldest_cc.number) begin
            $error("cc_number expected %0d actual %0d", oldest_cc.number, out_cc_number);
            errors++;
          end
          if (out_cc_value !== oldest_cc.value) begin
            $error("cc_value expected %0d actual %0d", oldest_cc.value, out_cc_value);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ALPHA: alpha_reg = cfg_data[ALPHA_W-1:0];
          CFG_ZONE: zone_reg = cfg_data;
          CFG_HYST: hyst_reg = cfg_data;
          CFG_GROUP: group_reg = cfg_data[CC_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        predict_control_change(in_func, in_distance_mm, in_touched);
      end
    end
  end

  task automatic add_item(input logic [1:0] func, input logic [FIELD_W-1:0] mm,
                          input logic touched);
    pad_or_distance_t it;
    it.func = func;
    it.distance = mm;
    it.touched = touched;
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || cc_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_items(input int zone, input int count);
    int pick;
    int lim;
    logic [FIELD_W-1:0] mm;
    lim = zone + zone / 2;
    if (lim > 65535) begin
      lim = 65535;
    end
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      mm = FIELD_W'($urandom);
      if (pick < 70) begin
        // a hand drifting around the zone, a jump near it, or a random distance
        if (pick < 25) begin
          drift_mm = drift_mm + int'($urandom_range(40)) - 20;
          if (drift_mm < 0) drift_mm = 0;
          if (drift_mm > lim) drift_mm = lim;
          mm = FIELD_W'(drift_mm);
        end else if (pick < 55) begin
          mm = FIELD_W'($urandom_range(lim));
          drift_mm = int'(mm);
        end
        add_item(FUNC_DIST, mm, 1'($urandom));
      end else if (pick < 82) begin
        add_item(FUNC_PRIMARY, mm, 1'($urandom));
      end else if (pick < 95) begin
        add_item(FUNC_SECONDARY, mm, 1'($urandom));
      end else begin
        add_item(FUNC_UNUSED, mm, 1'($urandom));
      end
    end
  endtask

  task automatic run_phase(input logic [FIELD_W-1:0] alpha, input logic [FIELD_W-1:0] zone,
                           input logic [FIELD_W-1:0] hyst, input logic [FIELD_W-1:0] group);
    wait_idle();
    write_reg(CFG_ALPHA, alpha);
    write_reg(CFG_ZONE, zone);
    write_reg(CFG_HYST, hyst);
    write_reg(CFG_GROUP, group);
    random_items(int'(zone), PHASE_ITEMS);
  endtask

  initial begin
    logic [FIELD_W-1:0] rnd_zone;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed, register defaults
    add_item(FUNC_DIST, 16'hFFFF, 1'b1);
    add_item(FUNC_DIST, 16'd0, 1'b0);
    add_item(FUNC_DIST, 16'd399, 1'b0);
    add_item(FUNC_DIST, 16'd200, 1'b0);
    add_item(FUNC_DIST, 16'd200, 1'b1);
    add_item(FUNC_SECONDARY, 16'hFFFF, 1'b1);
    add_item(FUNC_SECONDARY, 16'd0, 1'b1);
    add_item(FUNC_SECONDARY, 16'd0, 1'b0);
    // freeze, move while frozen, unfreeze
    add_item(FUNC_PRIMARY, 16'd0, 1'b1);
    add_item(FUNC_DIST, 16'd380, 1'b0);
    add_item(FUNC_DIST, 16'd100, 1'b0);
    add_item(FUNC_PRIMARY, 16'd0, 1'b1);
    add_item(FUNC_PRIMARY, 16'hFFFF, 1'b0);
    add_item(FUNC_PRIMARY, 16'd0, 1'b1);
    add_item(FUNC_DIST, 16'd100, 1'b0);
    add_item(FUNC_UNUSED, 16'hFFFF, 1'b1);
    add_item(FUNC_DIST, 16'd400, 1'b0);
    add_item(FUNC_DIST, 16'hFFFF, 1'b0);
    add_item(FUNC_DIST, 16'd351, 1'b0);
    add_item(FUNC_DIST, 16'd349, 1'b0);
    add_item(FUNC_DIST, 16'd360, 1'b0);
    add_item(FUNC_DIST, 16'd400, 1'b0);
    random_items(int'(ZONE_RST), PHASE_ITEMS);

    wait_idle();
    quiet = 1'b1;
    run_phase(16'd256, 16'hFFFF, 16'd0, 16'd127);
    wait_idle();
    quiet = 1'b0;
    run_phase(16'd1, 16'd1, 16'hFFFF, 16'h55);
    run_phase(16'd0, 16'd1000, 16'd100, 16'd0);
    run_phase(16'hFFFF, 16'd0, 16'd0, 16'd126);
    run_phase(16'd128, 16'd200, 16'd300, 16'd1);
    rnd_zone = FIELD_W'($urandom_range(2000, 1));
    run_phase(FIELD_W'($urandom_range(256, 1)), rnd_zone, FIELD_W'($urandom_range(rnd_zone)),
              FIELD_W'($urandom_range(127)));
    run_phase(FIELD_W'($urandom_range(256, 1)), FIELD_W'($urandom_range(65535, 1)),
              FIELD_W'($urandom), FIELD_W'($urandom));

    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
